// ===== rtl/pfg_pkg.sv =====
// Package for the page frame gap scorer: payload, configuration and state types,
// register indexes and limits shared by all modules in rtl/.
// No dependencies.
package pfg_pkg;

	// Fixed field widths
	localparam int FRAME_W  = 32;
	localparam int PAGES_W  = 21;
	localparam int MASK_W   = 32;
	localparam int TRIALS_W = 11;
	localparam int GAPS_W   = 20;
	localparam int INDEX_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Limits
	localparam logic [PAGES_W-1:0]  BLOCK_PAGES_MAX = PAGES_W'(1048576);
	localparam logic [GAPS_W-1:0]   GAP_MAX         = '1;
	localparam logic [TRIALS_W-1:0] MAX_TRIALS      = TRIALS_W'(1024);

	// Register reset values
	localparam logic [PAGES_W-1:0]  BLOCK_PAGES_RST = PAGES_W'(256);
	localparam logic [MASK_W-1:0]   CACHE_MASK_RST  = MASK_W'(255);
	localparam logic [TRIALS_W-1:0] MAX_TRIALS_RST  = TRIALS_W'(1024);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_PAGES = 2'd0,
		CFG_CACHE_MASK  = 2'd1,
		CFG_MAX_TRIALS  = 2'd2
	} cfg_idx_t;

	// Input transaction
	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic               new_search;
	} pfg_in_t;

	// Output transaction
	typedef struct packed {
		logic [INDEX_W-1:0] trial_index;
		logic               block_fits;
		logic [GAPS_W-1:0]  gap_count;
		logic [INDEX_W-1:0] best_trial;
		logic [GAPS_W-1:0]  best_gaps;
		logic               have_best;
		logic               search_done;
		logic               map_error;
	} pfg_out_t;

	// Clamped configuration as seen by the scorer
	typedef struct packed {
		logic [PAGES_W-1:0]  pages;
		logic [MASK_W-1:0]   cache_mask;
		logic [TRIALS_W-1:0] trials;
	} pfg_cfg_t;

	// Search state
	typedef struct packed {
		logic [FRAME_W-1:0] prev_frame;
		logic [GAPS_W-1:0]  page_index;
		logic [GAPS_W-1:0]  block_gaps;
		logic               block_failed;
		logic [INDEX_W-1:0] trial_count;
		logic [INDEX_W-1:0] best_index;
		logic [GAPS_W-1:0]  best_gap_count;
		logic               best_valid;
		logic               done_flag;
		logic               error_flag;
	} pfg_state_t;

endpackage

// ===== rtl/pfg_cfg.sv =====
// Configuration registers of the page frame gap scorer, with range clamping.
// Depends on pfg_pkg.
module pfg_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pfg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pfg_pkg::pfg_cfg_t                 cfg
);

	logic [pfg_pkg::PAGES_W-1:0]  block_pages_q;
	logic [pfg_pkg::MASK_W-1:0]   cache_mask_q;
	logic [pfg_pkg::TRIALS_W-1:0] max_trials_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_pages_q <= pfg_pkg::BLOCK_PAGES_RST;
			cache_mask_q  <= pfg_pkg::CACHE_MASK_RST;
			max_trials_q  <= pfg_pkg::MAX_TRIALS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfg_pkg::CFG_BLOCK_PAGES: block_pages_q <= cfg_data[pfg_pkg::PAGES_W-1:0];
				pfg_pkg::CFG_CACHE_MASK:  cache_mask_q  <= cfg_data[pfg_pkg::MASK_W-1:0];
				pfg_pkg::CFG_MAX_TRIALS:  max_trials_q  <= cfg_data[pfg_pkg::TRIALS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp block size and trial limit into their legal ranges
	always_comb begin
		cfg.cache_mask = cache_mask_q;
		if (block_pages_q == '0)
			cfg.pages = pfg_pkg::PAGES_W'(1);
		else if (block_pages_q > pfg_pkg::BLOCK_PAGES_MAX)
			cfg.pages = pfg_pkg::BLOCK_PAGES_MAX;
		else
			cfg.pages = block_pages_q;
		if (max_trials_q == '0)
			cfg.trials = pfg_pkg::TRIALS_W'(1);
		else if (max_trials_q > pfg_pkg::MAX_TRIALS)
			cfg.trials = pfg_pkg::MAX_TRIALS;
		else
			cfg.trials = max_trials_q;
	end

endmodule

// ===== rtl/pfg_scorer.sv =====
// Search state and per-frame scoring logic of the page frame gap scorer.
// Depends on pfg_pkg.
module pfg_scorer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  pfg_pkg::pfg_in_t    item,
	input  pfg_pkg::pfg_cfg_t   cfg,
	output logic                emit,
	output pfg_pkg::pfg_out_t   result
);

	pfg_pkg::pfg_state_t st_q;
	pfg_pkg::pfg_state_t cur;
	pfg_pkg::pfg_state_t nxt;

	logic [pfg_pkg::FRAME_W-1:0] next_frame;
	logic [pfg_pkg::PAGES_W-1:0] page_inc;
	logic [pfg_pkg::TRIALS_W-1:0] trial_inc;
	logic                         fits;
	logic [pfg_pkg::GAPS_W-1:0]   gaps;
	logic                         tail;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (step_en)
			st_q <= nxt;
	end

	// One frame per cycle while step_en is high
	always_comb begin
		cur        = item.new_search ? '0 : st_q;
		nxt        = cur;
		emit       = 1'b0;
		tail       = 1'b0;
		fits       = 1'b0;
		gaps       = '0;
		next_frame = cur.prev_frame + pfg_pkg::FRAME_W'(1);
		page_inc   = {1'b0, cur.page_index} + pfg_pkg::PAGES_W'(1);
		trial_inc  = {1'b0, cur.trial_count} + pfg_pkg::TRIALS_W'(1);

		if (!cur.done_flag) begin
			if (cur.page_index == '0) begin
				if (item.frame_number == '0) begin
					// unreadable page map: report and end the search
					nxt.error_flag   = 1'b1;
					nxt.done_flag    = 1'b1;
					nxt.page_index   = '0;
					nxt.block_gaps   = '0;
					nxt.block_failed = 1'b0;
					emit             = 1'b1;
				end else begin
					nxt.prev_frame = item.frame_number;
					tail           = 1'b1;
				end
			end else begin
				tail = 1'b1;
				if (!cur.block_failed) begin
					// frame break: tolerated only if clear of the cache mask
					if (item.frame_number != next_frame) begin
						if (((next_frame | item.frame_number) & cfg.cache_mask) != '0)
							nxt.block_failed = 1'b1;
						else if (cur.block_gaps < pfg_pkg::GAP_MAX)
							nxt.block_gaps = cur.block_gaps + pfg_pkg::GAPS_W'(1);
					end
					nxt.prev_frame = item.frame_number;
				end
			end
		end

		// fit and gap count of the current block, before it is closed
		fits = !nxt.block_failed;
		gaps = nxt.block_gaps;

		// per frame: advance the page index, or at the end of the block score it and open the next one
		if (tail) begin
			if (page_inc < cfg.pages) begin
				nxt.page_index = page_inc[pfg_pkg::GAPS_W-1:0];
			end else begin
				emit = 1'b1;
				if (fits && (!cur.best_valid || gaps < cur.best_gap_count)) begin
					nxt.best_valid     = 1'b1;
					nxt.best_index     = cur.trial_count;
					nxt.best_gap_count = gaps;
					if (gaps == '0)
						nxt.done_flag = 1'b1;
				end
				if (trial_inc >= cfg.trials)
					nxt.done_flag = 1'b1;
				nxt.trial_count  = cur.trial_count + pfg_pkg::INDEX_W'(1);
				nxt.page_index   = '0;
				nxt.block_gaps   = '0;
				nxt.block_failed = 1'b0;
			end
		end

		// result fields
		result.trial_index = cur.trial_count;
		result.block_fits  = tail ? fits : 1'b0;
		result.gap_count   = tail ? gaps : '0;
		result.best_trial  = nxt.best_index;
		result.best_gaps   = nxt.best_gap_count;
		result.have_best   = nxt.best_valid;
		result.search_done = nxt.done_flag;
		result.map_error   = nxt.error_flag;
	end

endmodule

// ===== rtl/page_frame_gap_scorer_core.sv =====
// Top level of the page frame gap scorer: input register, result register and
// handshakes around pfg_cfg and pfg_scorer. Depends on pfg_pkg.
//
//   channel   direction  handshake            payload
//   in        in         in_valid / in_stall  in_data   (pfg_in_t)
//   out       out        out_valid / out_stall out_data (pfg_out_t)
//   cfg       in         cfg_wr_en            cfg_index, cfg_data
//
// A frame is registered on acceptance and scored when stage 1 advances; the
// last frame's result is loaded into the result register and raises out_valid.
// One frame per cycle unless stalled: the single result register sets the rate;
// while it is stalled and full, the input stage fills and in_stall rises.
// arst_n clears the search state and loads the register reset values.
module page_frame_gap_scorer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pfg_pkg::pfg_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pfg_pkg::pfg_out_t              out_data,
	input  logic                           cfg_wr_en,
	input  logic [pfg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfg_pkg::CFG_DATA_W-1:0] cfg_data
);

	pfg_pkg::pfg_cfg_t cfg;
	pfg_pkg::pfg_in_t  data_s1;
	logic              valid_s1;
	pfg_pkg::pfg_out_t out_data_q;
	logic              out_valid_q;
	pfg_pkg::pfg_out_t result;
	logic              emit;
	logic              adv;
	logic              proc;

	pfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 advances whenever the result register is free or draining
	assign adv      = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	pfg_scorer u_scorer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (proc),
		.item    (data_s1),
		.cfg     (cfg),
		.emit    (emit),
		.result  (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)
			valid_s1 <= 1'b1;
		else if (proc)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			data_s1 <= in_data;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= proc && emit;
	end

	always_ff @(posedge clk) begin
		if (proc && emit)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	// Stall only backs up a held transaction
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty input stage");

	// A map error always ends the search and never reports a fit
	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.map_error |-> out_data.search_done && !out_data.block_fits)
		else $error("map error result without search end");

	// The best block can never have more gaps than a usable block just scored
	a_best_is_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.block_fits && !out_data.map_error
		|-> out_data.have_best && out_data.best_gaps <= out_data.gap_count)
		else $error("best gap count exceeds a usable block");
`endif

endmodule
